/* hdl/weighted_window_smoothing_defines.svh */
// ----------------------------------------------------------------------------
// Weighted window smoothing: assertion macros
// Concurrent check macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_WINDOW_SMOOTHING_DEFINES_SVH
`define WEIGHTED_WINDOW_SMOOTHING_DEFINES_SVH

`ifndef SYNTHESIS
`define WWS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("weighted_window_smoothing: check failed");
`define WWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("weighted_window_smoothing: sequence check failed");
`else
`define WWS_ASSERT(lbl, clk, rstn, prop)
`define WWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hdl/wws_pkg.sv */
// ----------------------------------------------------------------------------
// Weighted window smoothing: package
// Shared constants, codes and state type.
// ----------------------------------------------------------------------------
`default_nettype none

package wws_pkg;

    localparam int DEF_MAX_RADIUS = 2;
    localparam int DEF_MAX_WIDTH  = 1024;

    localparam int FUNC_W     = 2;
    localparam int PIX_W      = 8;
    localparam int WIDX_W     = 5;
    localparam int WGT_W      = 8;
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int RADREG_W   = 2;
    localparam int ROW_W      = 11;
    localparam int QUOT_W     = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DRAIN = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE  = 2'd3;

    localparam logic [CFG_W-1:0]    RST_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0]    RST_HEIGHT = 11'd480;
    localparam logic [RADREG_W-1:0] RST_RADIUS = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TAP,
        S_FLUSH,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

/* hdl/wws_ram.sv */
// ----------------------------------------------------------------------------
// Weighted window smoothing: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/wws_div.sv */
// ----------------------------------------------------------------------------
// Weighted window smoothing: divider
// Restoring division, one quotient bit per cycle, 8-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module wws_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 13
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [NUM_W-1:0]          i_num,
    input  wire logic [DEN_W-1:0]          i_den,
    output logic                           o_done,
    output logic [wws_pkg::QUOT_W-1:0]     o_quot
);

    localparam int SH_W  = DEN_W + wws_pkg::QUOT_W - 1;
    localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
    localparam int CNT_W = $clog2(wws_pkg::QUOT_W);

    logic [CMP_W-1:0] r_rem;
    logic [CMP_W-1:0] r_dsh;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(wws_pkg::QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= CMP_W'(i_num);
            r_dsh  <= CMP_W'({i_den, {(wws_pkg::QUOT_W - 1){1'b0}}});
            o_quot <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                r_rem  <= r_rem - r_dsh;
                o_quot <= {o_quot[wws_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                o_quot <= {o_quot[wws_pkg::QUOT_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

endmodule

`default_nettype wire

/* hdl/weighted_window_smoothing.sv */
// ----------------------------------------------------------------------------
// Weighted window smoothing: top level
// Normalized 2D window filter over a line-buffer RAM with border renormalizing.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata pixel/weight, tuser func
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata pixel, tuser zero flag, tlast
//  cfg       in   i_cfg_we                      i_cfg_addr, i_cfg_wdata
//
// A load or unused word is taken in S_IDLE alone; a pixel or drain word goes on
// to S_CHECK, and one that yields a result then runs S_TAP with one line-RAM read
// per window tap, S_FLUSH, S_DIV_START, S_DIV_WAIT for the 8-step divider and
// S_EMIT. Reset is synchronous; the line RAM needs no clearing pass. A result
// still held in the output register stalls the next result, and with it the input.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weighted_window_smoothing_defines.svh"

module weighted_window_smoothing #(
    parameter int MAX_RADIUS = wws_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = wws_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // pixel_in[7:0], weight_index[12:8], weight_value[20:13], zero fill
    input  wire logic [wws_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // func[1:0]
    input  wire logic [wws_pkg::FUNC_W-1:0]          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // pixel_out[7:0]
    output logic [wws_pkg::M_TDATA_W-1:0]            m_axis_tdata,
    // zero_divisor[0]
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast,
    input  wire logic                                i_cfg_we,
    input  wire logic [wws_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire logic [wws_pkg::CFG_W-1:0]           i_cfg_wdata
);

    localparam int KSIDE     = 2 * MAX_RADIUS + 1;
    localparam int KSIZE     = KSIDE * KSIDE;
    localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
    localparam int RING_W    = $clog2(RING_ROWS);
    localparam int RT_W      = RING_W + 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int AW        = $clog2(MAX_WIDTH + 1);
    localparam int XX_W      = AW + 1;
    localparam int ROW_W     = wws_pkg::ROW_W;
    localparam int YY_W      = ROW_W + 1;
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
    localparam int KS_W      = $clog2(KSIDE);
    localparam int KIDX_W    = $clog2(KSIZE);
    localparam int ACC_W     = $clog2(KSIZE * 255 * 255 + 1);
    localparam int WSUM_W    = $clog2(KSIZE * 255 + 1);
    localparam int ADDR_W    = RING_W + COL_W;
    localparam int DEPTH     = RING_ROWS * (2 ** COL_W);
    localparam int PIX_W     = wws_pkg::PIX_W;

    wws_pkg::t_state r_state, n_state;

    logic [wws_pkg::CFG_W-1:0]    r_cfg_w, r_cfg_h;
    logic [wws_pkg::RADREG_W-1:0] r_cfg_r;
    logic [AW-1:0]                r_act_w;
    logic [ROW_W-1:0]             r_act_h;
    logic [RAD_W-1:0]             r_act_r;
    logic                         r_active;
    logic [COL_W-1:0]             r_in_col, r_out_col;
    logic [ROW_W-1:0]             r_in_row, r_out_row;
    logic [RING_W-1:0]            r_in_ring, r_out_ring;
    logic [wws_pkg::WGT_W-1:0]    r_kern [KSIZE];
    logic [KS_W-1:0]              r_dy, r_dx;
    logic [KIDX_W-1:0]            r_kidx;
    logic                         r_p_valid, r_p_in;
    logic [wws_pkg::WGT_W-1:0]    r_p_k;
    logic [ACC_W-1:0]             r_acc;
    logic [WSUM_W-1:0]            r_wsum;
    logic                         r_out_valid, r_out_zd, r_out_last;
    logic [PIX_W-1:0]             r_out_pix;

    logic                         s_accept;
    logic [wws_pkg::FUNC_W-1:0]   s_func;
    logic [PIX_W-1:0]             s_pix;
    logic [wws_pkg::WIDX_W-1:0]   s_widx;
    logic [wws_pkg::WGT_W-1:0]    s_wval;
    logic [AW-1:0]                eff_w, cur_w;
    logic [ROW_W-1:0]             eff_h, cur_h;
    logic [RAD_W-1:0]             eff_r;
    logic                         ram_we, div_start, div_done, emit_go;
    logic [PIX_W-1:0]             ram_rdata;
    logic [wws_pkg::QUOT_W-1:0]   div_quot;
    logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
    logic                         in_wrap;
    logic [YY_W-1:0]              ny_raw, yy;
    logic [ROW_W-1:0]             ny, hm1;
    logic [XX_W-1:0]              nx_raw, xx;
    logic [AW-1:0]                nx, wm1;
    logic                         out_ready;
    logic                         ok_y, ok_x, tap_last;
    logic [KS_W-1:0]              two_r;
    logic [RT_W-1:0]              rt0, rt1, rt2;
    logic [COL_W-1:0]             tap_col;
    logic                         out_last;
    logic                         out_behind;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign s_func   = s_axis_tuser;
    assign s_pix    = s_axis_tdata[7:0];
    assign s_widx   = s_axis_tdata[12:8];
    assign s_wval   = s_axis_tdata[20:13];

    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = AW'(1);
        end else if (XX_W'(r_cfg_w) > XX_W'(MAX_WIDTH)) begin
            eff_w = AW'(MAX_WIDTH);
        end else begin
            eff_w = AW'(r_cfg_w);
        end
        eff_h = (r_cfg_h == '0) ? ROW_W'(1) : r_cfg_h;
        eff_r = (32'(r_cfg_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_cfg_r);
        cur_w = r_active ? r_act_w : eff_w;
        cur_h = r_active ? r_act_h : eff_h;
    end

    assign ram_waddr = {r_in_ring, r_in_col};
    assign in_wrap   = (AW'(r_in_col) + AW'(1)) >= cur_w;

    always_comb begin
        hm1    = r_act_h - ROW_W'(1);
        ny_raw = YY_W'(r_out_row) + YY_W'(r_act_r);
        ny     = (ny_raw > YY_W'(hm1)) ? hm1 : ny_raw[ROW_W-1:0];
        wm1    = r_act_w - AW'(1);
        nx_raw = XX_W'(r_out_col) + XX_W'(r_act_r);
        nx     = (nx_raw > XX_W'(wm1)) ? wm1 : nx_raw[AW-1:0];
        out_ready = r_active && (r_out_row < r_act_h)
                  && ((ny < r_in_row) || ((ny == r_in_row) && (nx < AW'(r_in_col))));
        out_last  = (r_out_row == hm1) && (AW'(r_out_col) == wm1);
    end

    assign out_behind = (r_out_row < r_in_row)
                      || ((r_out_row == r_in_row) && (r_out_col <= r_in_col));

    always_comb begin
        two_r    = KS_W'({r_act_r, 1'b0});
        yy       = YY_W'(r_out_row) + YY_W'(r_dy);
        xx       = XX_W'(r_out_col) + XX_W'(r_dx);
        ok_y     = (yy >= YY_W'(r_act_r)) && ((yy - YY_W'(r_act_r)) < YY_W'(r_act_h));
        ok_x     = (xx >= XX_W'(r_act_r)) && ((xx - XX_W'(r_act_r)) < XX_W'(r_act_w));
        tap_col  = COL_W'(xx - XX_W'(r_act_r));
        rt0      = RT_W'(r_out_ring) + RT_W'(r_dy) + RT_W'(RING_ROWS) - RT_W'(r_act_r);
        rt1      = (rt0 >= RT_W'(RING_ROWS)) ? rt0 - RT_W'(RING_ROWS) : rt0;
        rt2      = (rt1 >= RT_W'(RING_ROWS)) ? rt1 - RT_W'(RING_ROWS) : rt1;
        ram_raddr = {rt2[RING_W-1:0], tap_col};
        tap_last = (r_dx == two_r) && (r_dy == two_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        div_start     = 1'b0;
        emit_go       = 1'b0;
        unique case (r_state)
            wws_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_accept) begin
                    if (s_func == wws_pkg::FUNC_PIXEL) begin
                        ram_we  = (r_in_row < cur_h);
                        n_state = wws_pkg::S_CHECK;
                    end else if (s_func == wws_pkg::FUNC_DRAIN) begin
                        n_state = wws_pkg::S_CHECK;
                    end
                end
            end
            wws_pkg::S_CHECK: begin
                n_state = out_ready ? wws_pkg::S_TAP : wws_pkg::S_IDLE;
            end
            wws_pkg::S_TAP: begin
                if (tap_last) begin
                    n_state = wws_pkg::S_FLUSH;
                end
            end
            wws_pkg::S_FLUSH: begin
                n_state = wws_pkg::S_DIV_START;
            end
            wws_pkg::S_DIV_START: begin
                div_start = 1'b1;
                n_state   = wws_pkg::S_DIV_WAIT;
            end
            wws_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = wws_pkg::S_EMIT;
                end
            end
            wws_pkg::S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    emit_go = 1'b1;
                    n_state = wws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wws_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= wws_pkg::RST_WIDTH;
            r_cfg_h     <= wws_pkg::RST_HEIGHT;
            r_cfg_r     <= wws_pkg::RST_RADIUS;
            r_act_w     <= AW'(wws_pkg::RST_WIDTH);
            r_act_h     <= wws_pkg::RST_HEIGHT;
            r_act_r     <= RAD_W'(wws_pkg::RST_RADIUS);
            r_active    <= 1'b0;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_ring   <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_ring  <= '0;
            r_out_valid <= 1'b0;
            r_p_valid   <= 1'b0;
            for (int i = 0; i < KSIZE; i++) begin
                r_kern[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    wws_pkg::REG_WIDTH:  r_cfg_w <= i_cfg_wdata;
                    wws_pkg::REG_HEIGHT: r_cfg_h <= i_cfg_wdata;
                    wws_pkg::REG_RADIUS: r_cfg_r <= i_cfg_wdata[wws_pkg::RADREG_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (s_accept && (s_func == wws_pkg::FUNC_LOAD)
                    && (32'(s_widx) < KSIZE)) begin
                r_kern[KIDX_W'(s_widx)] <= s_wval;
            end

            if (s_accept && (s_func == wws_pkg::FUNC_PIXEL)) begin
                if (!r_active) begin
                    r_act_w  <= eff_w;
                    r_act_h  <= eff_h;
                    r_act_r  <= eff_r;
                    r_active <= 1'b1;
                end
                if (ram_we) begin
                    if (in_wrap) begin
                        r_in_col  <= '0;
                        r_in_row  <= r_in_row + ROW_W'(1);
                        r_in_ring <= (r_in_ring == RING_W'(RING_ROWS - 1))
                                   ? '0 : r_in_ring + RING_W'(1);
                    end else begin
                        r_in_col <= r_in_col + COL_W'(1);
                    end
                end
            end

            r_p_valid <= (r_state == wws_pkg::S_TAP);

            if (emit_go) begin
                r_out_valid <= 1'b1;
                if (out_last) begin
                    r_active   <= 1'b0;
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_in_ring  <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_ring <= '0;
                end else if (AW'(r_out_col) == wm1) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + ROW_W'(1);
                    r_out_ring <= (r_out_ring == RING_W'(RING_ROWS - 1))
                                ? '0 : r_out_ring + RING_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == wws_pkg::S_CHECK) begin
            r_dy   <= '0;
            r_dx   <= '0;
            r_kidx <= '0;
            r_acc  <= '0;
            r_wsum <= '0;
        end else begin
            if (r_state == wws_pkg::S_TAP) begin
                r_kidx <= r_kidx + KIDX_W'(1);
                if (r_dx == two_r) begin
                    r_dx <= '0;
                    r_dy <= r_dy + KS_W'(1);
                end else begin
                    r_dx <= r_dx + KS_W'(1);
                end
            end
            if (r_p_valid && r_p_in) begin
                r_acc  <= r_acc + ACC_W'(ram_rdata * r_p_k);
                r_wsum <= r_wsum + WSUM_W'(r_p_k);
            end
        end
        r_p_in <= ok_y && ok_x;
        r_p_k  <= r_kern[r_kidx];
        if (emit_go) begin
            r_out_pix  <= (r_wsum == '0) ? '0 : div_quot;
            r_out_zd   <= (r_wsum == '0);
            r_out_last <= out_last;
        end
    end

    wws_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (s_pix),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    wws_div #(
        .NUM_W (ACC_W),
        .DEN_W (WSUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (r_wsum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tuser  = r_out_zd;
    assign m_axis_tlast  = r_out_last;

    `WWS_ASSERT(a_in_bound, i_clk, i_rst_n, r_active |-> (r_in_row <= r_act_h))
    `WWS_ASSERT(a_out_behind, i_clk, i_rst_n, r_active |-> out_behind)
    `WWS_ASSERT(a_zero_pix, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    `WWS_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, emit_go, m_axis_tvalid)

endmodule

`default_nettype wire

/* bench/tb_weighted_window_smoothing.sv */
// ----------------------------------------------------------------------------
// Weighted window smoothing: testbench
// Drives weight loads, pixel frames and drain words with random gaps and
// output stalls, predicts every result from an internal model of the filter
// and compares each accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct packed {
    logic [7:0] pix;
    logic       zdiv;
    logic       last;
} t_smooth_res;

class smooth_scoreboard;
    t_smooth_res pending_q[$];
    int          n_err;
    logic [7:0]  kern[25];
    logic [7:0]  lines[6][1024];
    int          in_c, in_r, out_c, out_r;
    int          reg_w, reg_h, reg_r;
    int          w, h, r;
    bit          busy;

    function new();
        foreach (kern[i]) kern[i] = '0;
        reg_w = 640; reg_h = 480; reg_r = 1;
        w = 640; h = 480; r = 1;
        busy = 0;
        in_c = 0; in_r = 0; out_c = 0; out_r = 0;
        n_err = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [10:0] val);
        if (idx == wws_pkg::REG_WIDTH) reg_w = val;
        else if (idx == wws_pkg::REG_HEIGHT) reg_h = val;
        else if (idx == wws_pkg::REG_RADIUS) reg_r = val[1:0];
    endfunction

    function bit ready_to_emit();
        int ny, nx;
        if (!busy || out_r >= h) return 0;
        ny = (out_r + r > h - 1) ? h - 1 : out_r + r;
        nx = (out_c + r > w - 1) ? w - 1 : out_c + r;
        return (ny < in_r) || (ny == in_r && nx < in_c);
    endfunction

    function void emit_one();
        int unsigned acc, wsum, k;
        int y, x;
        t_smooth_res res;
        bit lst;
        if (!ready_to_emit()) return;
        acc = 0; wsum = 0;
        for (int dy = -r; dy <= r; dy++)
            for (int dx = -r; dx <= r; dx++) begin
                y = out_r + dy; x = out_c + dx;
                k = kern[(dy + r) * (2 * r + 1) + dx + r];
                if (y < 0 || y >= h || x < 0 || x >= w) continue;
                acc += lines[y % 6][x] * k;
                wsum += k;
            end
        lst = (out_r == h - 1) && (out_c == w - 1);
        res.pix = wsum ? 8'((acc / wsum) & 255) : 8'd0;
        res.zdiv = (wsum == 0);
        res.last = lst;
        pending_q.push_back(res);
        if (lst) begin
            in_c = 0; in_r = 0; out_c = 0; out_r = 0; busy = 0;
        end else if (++out_c >= w) begin
            out_c = 0; out_r++;
        end
    endfunction

    function void note_word(logic [1:0] fn, logic [23:0] d);
        if (fn == wws_pkg::FUNC_LOAD) begin
            if (d[12:8] < 25) kern[d[12:8]] = d[20:13];
        end else if (fn == wws_pkg::FUNC_PIXEL) begin
            if (!busy) begin
                w = reg_w == 0 ? 1 : (reg_w > 1024 ? 1024 : reg_w);
                h = reg_h == 0 ? 1 : reg_h;
                r = reg_r > 2 ? 2 : reg_r;
                in_c = 0; in_r = 0; out_c = 0; out_r = 0; busy = 1;
            end
            if (in_r < h) begin
                lines[in_r % 6][in_c] = d[7:0];
                if (++in_c >= w) begin
                    in_c = 0; in_r++;
                end
            end
            emit_one();
        end else if (fn == wws_pkg::FUNC_DRAIN) begin
            emit_one();
        end
    endfunction

    function void check_word(t_smooth_res got);
        t_smooth_res exp_r;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected word exp none act %h", $time, got);
            n_err++;
            return;
        end
        exp_r = pending_q.pop_front();
        if (got.pix !== exp_r.pix) begin
            $display("%0t: pixel exp %0d act %0d", $time, exp_r.pix, got.pix);
            n_err++;
        end
        if (got.zdiv !== exp_r.zdiv) begin
            $display("%0t: zero flag exp %0d act %0d", $time, exp_r.zdiv, got.zdiv);
            n_err++;
        end
        if (got.last !== exp_r.last) begin
            $display("%0t: tlast exp %0d act %0d", $time, exp_r.last, got.last);
            n_err++;
        end
    endfunction
endclass

module tb_weighted_window_smoothing;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_addr = '0;
    logic [10:0] i_cfg_wdata = '0;

    smooth_scoreboard sb = new();
    int  cycles = 0;
    bit  stall_on = 1;

    always #6 i_clk = ~i_clk;

    weighted_window_smoothing DUT (.*);

    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word('{m_axis_tdata, m_axis_tuser, m_axis_tlast});
        if (!stall_on) m_axis_tready <= 1;
        else m_axis_tready <= (gap_len() == 0);
    end

    task automatic send_word(logic [1:0] fn, logic [7:0] pix, logic [4:0] idx,
                             logic [7:0] wv);
        int g;
        g = stall_on ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= fn;
        s_axis_tdata <= {3'b0, wv, idx, pix};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(fn, {3'b0, wv, idx, pix});
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        s_axis_tvalid <= 0;
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic load_kernel(bit zeros);
        for (int i = 0; i < 25; i++)
            send_word(wws_pkg::FUNC_LOAD, 8'($urandom), 5'(i), zeros ? 8'd0 : 8'($urandom));
    endtask

    // push a whole frame of pixels mixed with some drain and unused-func noise words,
    // then drain until the frame ends
    task automatic run_frame(int fw, int fh, int noise);
        int n;
        n = fw * fh;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise)
                send_word($urandom_range(0, 1) ? wws_pkg::FUNC_DRAIN : wws_pkg::FUNC_SPARE,
                          8'($urandom), 5'($urandom), 8'($urandom));
            send_word(wws_pkg::FUNC_PIXEL, 8'($urandom), 5'($urandom), 8'($urandom));
        end
        while (sb.busy)
            send_word(wws_pkg::FUNC_DRAIN, 8'($urandom), 5'($urandom), 8'($urandom));
    endtask

    initial begin
        int fw, fh;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extreme weights, bad indexes, idle drain, unused func
        send_word(wws_pkg::FUNC_DRAIN, 8'hff, 5'h1f, 8'hff);
        send_word(wws_pkg::FUNC_SPARE, 8'hff, 5'h1f, 8'hff);
        send_word(wws_pkg::FUNC_LOAD, 8'h00, 5'd31, 8'hff);
        send_word(wws_pkg::FUNC_LOAD, 8'h00, 5'd25, 8'h55);
        write_reg(wws_pkg::REG_WIDTH, 11'd3);
        write_reg(wws_pkg::REG_HEIGHT, 11'd2);
        write_reg(wws_pkg::REG_RADIUS, 11'd1);
        // zero kernel gives zero divisor
        run_frame(3, 2, 0);
        wait_idle();
        load_kernel(0);
        send_word(wws_pkg::FUNC_LOAD, 8'h00, 5'd12, 8'hff);
        write_reg(wws_pkg::REG_WIDTH, 11'd0);
        write_reg(wws_pkg::REG_HEIGHT, 11'd0);
        write_reg(wws_pkg::REG_RADIUS, 11'd3);
        send_word(wws_pkg::FUNC_PIXEL, 8'hff, 5'h00, 8'h00);
        // pixel after full frame received acts as drain
        wait_idle();
        write_reg(wws_pkg::REG_WIDTH, 11'd2);
        write_reg(wws_pkg::REG_HEIGHT, 11'd1);
        send_word(wws_pkg::FUNC_PIXEL, 8'h00, 5'h1f, 8'hff);
        send_word(wws_pkg::FUNC_PIXEL, 8'hff, 5'h1f, 8'hff);
        while (sb.busy) send_word(wws_pkg::FUNC_PIXEL, 8'h12, 5'h00, 8'h00);
        wait_idle();
        // random phase
        for (int f = 0; f < 24; f++) begin
            stall_on = (f % 7 != 3);
            fw = $urandom_range(1, 6);
            fh = $urandom_range(1, 5);
            if (f % 10 == 9) write_reg(wws_pkg::REG_SPARE, 11'($urandom));
            write_reg(wws_pkg::REG_WIDTH, 11'(fw));
            write_reg(wws_pkg::REG_HEIGHT, 11'(fh));
            write_reg(wws_pkg::REG_RADIUS, 11'($urandom_range(0, 3)));
            if ($urandom_range(0, 2) == 0) load_kernel($urandom_range(0, 5) == 0);
            run_frame(fw, fh, 15);
            wait_idle();
        end
        stall_on = 1;
        wait_idle();
        if (sb.n_err == 0 && sb.pending_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
